// ===== rtl/core/blhm_pkg.sv =====
// Shared types and constants for the battery level hysteresis monitor.
package blhm_pkg;

  localparam int MV_W        = 13;
  localparam int SUM_W       = 19;
  localparam int AVG_SAMPLES = 8;
  localparam int CNT_W       = $clog2(AVG_SAMPLES + 1);

  // Trimmed mean divides by AVG_SAMPLES-2: reciprocal multiply, exact for SUM_W-bit sums.
  localparam int AVG_DIV   = AVG_SAMPLES - 2;
  localparam int DIV_SHIFT = SUM_W + $clog2(AVG_DIV);
  localparam int PROD_W    = SUM_W + DIV_SHIFT;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << DIV_SHIFT) + longint'(AVG_DIV) - 1) / longint'(AVG_DIV);
  localparam logic [DIV_SHIFT-1:0] RECIP = DIV_SHIFT'(RECIP_L);

  localparam logic [MV_W-1:0] MV_MAX         = '1;
  localparam logic [MV_W-1:0] TURBO_THR_MV   = 13'd3500;
  localparam logic [MV_W-1:0] NORMAL_THR_MV  = 13'd3700;
  localparam logic [MV_W-1:0] PLENTY_HYST_MV = 13'd200;
  localparam logic [MV_W-1:0] MID_LOW_MV     = 13'd3000;
  localparam logic [MV_W-1:0] LOW_MID_MV     = 13'd3200;
  localparam logic [MV_W-1:0] LOW_VLOW_MV    = 13'd2800;
  localparam logic [MV_W-1:0] VLOW_LOW_MV    = 13'd3000;
  localparam logic [MV_W-1:0] FAULT_MV       = 13'd2650;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_EVAL   = 2'd1,
    MODE_PRESET = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    LVL_PLENTY = 4'b0001,
    LVL_MID    = 4'b0010,
    LVL_LOW    = 4'b0100,
    LVL_VLOW   = 4'b1000
  } level_t;

  localparam logic [1:0] CHG_PLENTY = 2'd0;
  localparam logic [1:0] CHG_MID    = 2'd1;
  localparam logic [1:0] CHG_LOW    = 2'd2;
  localparam logic [1:0] CHG_VLOW   = 2'd3;

  typedef struct packed {
    logic            upd;
    logic [MV_W-1:0] avg;
  } avg_res_t;

  typedef struct packed {
    logic [1:0]      level;
    logic [MV_W-1:0] held;
    logic            alert;
    logic            fault;
  } lvl_res_t;

endpackage

// ===== rtl/core/blhm_if.sv =====
// Valid/ready channel interfaces for monitor items and results.
interface blhm_item_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [blhm_pkg::MV_W-1:0] sample_mv;
  logic                      turbo_active;
  logic [blhm_pkg::MV_W-1:0] alert_threshold_mv;

  modport source (output valid, mode, sample_mv, turbo_active, alert_threshold_mv,
                  input ready);
  modport sink   (input valid, mode, sample_mv, turbo_active, alert_threshold_mv,
                  output ready);
endinterface

interface blhm_result_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                charge_level;
  logic [blhm_pkg::MV_W-1:0] held_voltage_mv;
  logic                      alert_flag;
  logic                      fault_flag;
  logic                      average_updated;

  modport source (output valid, charge_level, held_voltage_mv, alert_flag, fault_flag,
                  average_updated, input ready);
  modport sink   (input valid, charge_level, held_voltage_mv, alert_flag, fault_flag,
                  average_updated, output ready);
endinterface

// ===== rtl/core/battery_level_hysteresis_monitor.sv =====
// Top level of the battery level hysteresis monitor.
//
// Usage:
//   item   : valid/ready channel of commands. mode 0 is a sample tick, mode 1
//            evaluates alert/fault flags and steps the charge level, mode 2
//            presets the held voltage and steps the level, mode 3 is a no-op.
//   result : one transfer per item: charge level, held voltage, flags and an
//            average_updated strobe set on the tick that closes a window.
//   Path: an accepted item passes the input register, then the result
//   register. Throughput is one item per cycle unless the result stalls; the
//   item/level/accumulator path is a single pass between those registers,
//   with one reciprocal multiply for the trimmed-mean divide.
//   Reset (rst, synchronous) empties both registers and clears the
//   accumulator, held voltage, flags and sets the level to plenty.
//   When the receiver stalls, the result register holds its transfer; the
//   input register still takes a new item while the result slot is full,
//   and item.ready drops only once both are occupied.
module battery_level_hysteresis_monitor (
  input  logic         clk,
  input  logic         rst,
  blhm_item_if.sink    item,
  blhm_result_if.source result
);
  import blhm_pkg::*;

  // Input register
  logic            in_vld;
  mode_t           mode_q;
  logic [MV_W-1:0] sample_q;
  logic            turbo_q;
  logic [MV_W-1:0] athr_q;

  // Result register
  logic            out_vld;
  lvl_res_t        out_q;
  logic            upd_q;

  logic            advance;
  logic            take;
  avg_res_t        avg_res;
  lvl_res_t        lvl_res;

  // Item moves into the result slot when it is free or being drained.
  assign advance    = in_vld && (!out_vld || result.ready);
  assign item.ready = !in_vld || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_q   <= mode_t'(item.mode);
      sample_q <= item.sample_mv;
      turbo_q  <= item.turbo_active;
      athr_q   <= item.alert_threshold_mv;
    end
  end

  // Accumulator only moves on sample ticks
  blhm_avg u_avg (
    .clk    (clk),
    .rst    (rst),
    .en     (advance && mode_q == MODE_TICK),
    .sample (sample_q),
    .res    (avg_res)
  );

  blhm_level u_level (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .mode   (mode_q),
    .sample (sample_q),
    .turbo  (turbo_q),
    .athr   (athr_q),
    .avg    (avg_res),
    .res    (lvl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= lvl_res;
      upd_q <= (mode_q == MODE_TICK) && avg_res.upd;
    end
  end

  assign result.valid           = out_vld;
  assign result.charge_level    = out_q.level;
  assign result.held_voltage_mv = out_q.held;
  assign result.alert_flag      = out_q.alert;
  assign result.fault_flag      = out_q.fault;
  assign result.average_updated = upd_q;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !result.ready) |=> out_vld)
    else $error("stalled result dropped");

endmodule

// ===== rtl/core/blhm_avg.sv =====
// Sample accumulator with min/max tracking and trimmed-mean divide.
module blhm_avg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [blhm_pkg::MV_W-1:0] sample,
  output blhm_pkg::avg_res_t        res
);
  import blhm_pkg::*;

  logic [SUM_W-1:0]     sample_sum;
  logic [CNT_W-1:0]     sample_count;
  logic [MV_W-1:0]      running_min;
  logic [MV_W-1:0]      running_max;

  logic                 full;
  logic [MV_W:0]        trim;
  logic [SUM_W-1:0]     trimmed;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     quot;

  assign full    = (sample_count == CNT_W'(AVG_SAMPLES));
  assign trim    = {1'b0, running_min} + {1'b0, running_max};
  assign trimmed = (sample_sum > SUM_W'(trim)) ? sample_sum - SUM_W'(trim) : '0;
  assign prod    = {{DIV_SHIFT{1'b0}}, trimmed} * {{SUM_W{1'b0}}, RECIP};
  assign quot    = prod[PROD_W-1:DIV_SHIFT];

  assign res.upd = full;
  assign res.avg = (quot > SUM_W'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || (en && full)) begin
      sample_sum   <= '0;
      sample_count <= '0;
      running_min  <= MV_MAX;
      running_max  <= '0;
    end else if (en) begin
      sample_sum   <= sample_sum + SUM_W'(sample);
      sample_count <= sample_count + CNT_W'(1);
      if (running_min > sample) running_min <= sample;
      if (running_max < sample) running_max <= sample;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(AVG_SAMPLES))
    else $error("sample count beyond window");

  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    (sample_count == '0) |-> (sample_sum == '0 && running_max == '0 &&
                              running_min == MV_MAX))
    else $error("empty accumulator not cleared");

  a_avg_clears: assert property (@(posedge clk) disable iff (rst)
    (en && full) |=> (sample_count == '0))
    else $error("accumulator kept after average");

endmodule

// ===== rtl/core/blhm_level.sv =====
// Held voltage, charge-level state machine with hysteresis, alert/fault flags.
module blhm_level (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  blhm_pkg::mode_t           mode,
  input  logic [blhm_pkg::MV_W-1:0] sample,
  input  logic                      turbo,
  input  logic [blhm_pkg::MV_W-1:0] athr,
  input  blhm_pkg::avg_res_t        avg,
  output blhm_pkg::lvl_res_t        res
);
  import blhm_pkg::*;

  logic [MV_W-1:0] held_voltage, held_voltage_next;
  level_t          level_state, level_state_next, stepped;
  logic            alert_reg, alert_reg_next;
  logic            fault_reg, fault_reg_next;
  logic [MV_W-1:0] thr, thr_hi;
  logic [1:0]      level_code;

  assign thr    = turbo ? TURBO_THR_MV : NORMAL_THR_MV;
  assign thr_hi = thr + PLENTY_HYST_MV;

  always_comb begin
    held_voltage_next = held_voltage;
    alert_reg_next    = alert_reg;
    fault_reg_next    = fault_reg;
    level_state_next  = level_state;

    case (mode)
      MODE_TICK:   if (avg.upd) held_voltage_next = avg.avg;
      MODE_PRESET: held_voltage_next = sample;
      MODE_EVAL: begin
        if (held_voltage > FAULT_MV) begin
          alert_reg_next = (held_voltage <= athr);
          fault_reg_next = 1'b0;
        end else begin
          alert_reg_next = 1'b0;
          fault_reg_next = 1'b1;
        end
      end
      default: ;
    endcase

    stepped = level_state;
    case (level_state)
      LVL_PLENTY: if (held_voltage_next < thr) stepped = LVL_MID;
      LVL_MID: begin
        if (held_voltage_next > thr_hi)     stepped = LVL_PLENTY;
        if (held_voltage_next < MID_LOW_MV) stepped = LVL_LOW;
      end
      LVL_LOW: begin
        if (held_voltage_next > LOW_MID_MV)  stepped = LVL_MID;
        if (held_voltage_next < LOW_VLOW_MV) stepped = LVL_VLOW;
      end
      LVL_VLOW: if (held_voltage_next > VLOW_LOW_MV) stepped = LVL_LOW;
      default: stepped = level_state;
    endcase
    if (mode == MODE_EVAL || mode == MODE_PRESET) level_state_next = stepped;
  end

  always_comb begin
    case (level_state_next)
      LVL_PLENTY: level_code = CHG_PLENTY;
      LVL_MID:    level_code = CHG_MID;
      LVL_LOW:    level_code = CHG_LOW;
      LVL_VLOW:   level_code = CHG_VLOW;
      default:    level_code = CHG_VLOW;
    endcase
  end
  assign res.level = level_code;
  assign res.held  = held_voltage_next;
  assign res.alert = alert_reg_next;
  assign res.fault = fault_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_voltage <= '0;
      level_state  <= LVL_PLENTY;
      alert_reg    <= 1'b0;
      fault_reg    <= 1'b0;
    end else if (en) begin
      held_voltage <= held_voltage_next;
      level_state  <= level_state_next;
      alert_reg    <= alert_reg_next;
      fault_reg    <= fault_reg_next;
    end
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(alert_reg && fault_reg))
    else $error("alert and fault both set");

  a_fault_set: assert property (@(posedge clk) disable iff (rst)
    (en && mode == MODE_EVAL && held_voltage <= FAULT_MV) |=> fault_reg)
    else $error("fault not raised at low voltage");

endmodule

// ===== test/battery_level_hysteresis_monitor_test.sv =====
// Self-checking testbench for the battery level hysteresis monitor: directed table plus random traffic.
module battery_level_hysteresis_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blhm_pkg::*;

  localparam int ITEM_COUNT  = 1450;   // random transfers after the table
  localparam int CALM_TAIL   = 150;    // last transfers run with no idling
  localparam int HOLD_AFTER  = 400;    // accepted transfers before the long sink stall
  localparam int HOLD_CYCLES = 80;     // length of that stall
  localparam int DRAIN_WAIT  = 8;      // block holds an input and a result register; leave margin
  localparam int TABLE_ROWS  = 26;

  // One command and the reading it should produce.
  typedef struct {
    mode_t           mode;
    logic [MV_W-1:0] sample;
    logic            turbo;
    logic [MV_W-1:0] athr;
  } cmd_t;

  typedef struct {
    logic [1:0]      level;
    logic [MV_W-1:0] held;
    logic            alert;
    logic            fault;
    logic            upd;
  } reading_t;

  // Directed row: pinned rows carry a hand-written reading, the rest use the predictor.
  typedef struct {
    mode_t           mode;
    logic [MV_W-1:0] sample;
    logic            turbo;
    logic [MV_W-1:0] athr;
    logic            pinned;
    logic [1:0]      level;
    logic [MV_W-1:0] held;
    logic            alert;
    logic            fault;
    logic            upd;
  } row_t;

  logic clk;
  logic rst;

  blhm_item_if   item_ch();
  blhm_result_if result_ch();

  battery_level_hysteresis_monitor DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // ------------------------------------------------------------------
  // Directed table. Threshold edges of every level transition, flag
  // edges at the fault limit and the alert threshold, mode 3 as a no-op,
  // and one full averaging window with extreme samples that get trimmed.
  // ------------------------------------------------------------------
  row_t dir_rows [TABLE_ROWS] = '{
    // idle command straight out of reset reports the reset state
    '{MODE_NONE,   13'd0,    1'b0, 13'd0,    1'b1, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    // held 0 is at/below fault limit; plenty drops to mid
    '{MODE_EVAL,   13'd8191, 1'b1, 13'd0,    1'b1, CHG_MID,    13'd0,    1'b0, 1'b1, 1'b0},
    // preset full scale; mid climbs to plenty, flags untouched
    '{MODE_PRESET, 13'd8191, 1'b0, 13'd8191, 1'b1, CHG_PLENTY, 13'd8191, 1'b0, 1'b1, 1'b0},
    // alert exactly at threshold, fault clears
    '{MODE_EVAL,   13'd0,    1'b0, 13'd8191, 1'b1, CHG_PLENTY, 13'd8191, 1'b1, 1'b0, 1'b0},
    // level hysteresis walk, normal and turbo thresholds
    '{MODE_PRESET, 13'd3699, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3900, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3901, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3499, 1'b1, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3701, 1'b1, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd2999, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd2999, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd2799, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3001, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd3201, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_PRESET, 13'd2650, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_EVAL,   13'd0,    1'b0, 13'd8191, 1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    // averaging window: min 0 and max 8191 are trimmed off
    '{MODE_TICK,   13'd0,    1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd8191, 1'b1, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_NONE,   13'd8191, 1'b1, 13'd8191, 1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    '{MODE_TICK,   13'd5000, 1'b0, 13'd0,    1'b0, CHG_PLENTY, 13'd0,    1'b0, 1'b0, 1'b0},
    // closing tick drops its sample: (38191 - 8191) / 6 = 5000; level stays very low
    '{MODE_TICK,   13'd1234, 1'b0, 13'd0,    1'b1, CHG_VLOW,   13'd5000, 1'b0, 1'b1, 1'b1}
  };

  // ------------------------------------------------------------------
  // Predictor state: accumulator, held voltage, level and flags.
  // ------------------------------------------------------------------
  logic [SUM_W-1:0] acc_sum   = '0;
  logic [6:0]       acc_count = '0;
  logic [MV_W-1:0]  acc_min   = MV_MAX;
  logic [MV_W-1:0]  acc_max   = '0;
  logic [MV_W-1:0]  held_mv   = '0;
  logic [1:0]       level     = CHG_PLENTY;
  logic             alert_st  = 1'b0;
  logic             fault_st  = 1'b0;

  reading_t pending_readings [$];   // readings owed by the block, oldest first
  int       mismatches = 0;
  int       accepted   = 0;         // item transfers so far
  bit       calm       = 1'b0;      // set for the tail: no idling on either side

  // Hysteresis step on the current held voltage.
  function automatic void step_level(logic turbo);
    int unsigned thr;
    int unsigned v;
    thr = turbo ? TURBO_THR_MV : NORMAL_THR_MV;
    v   = held_mv;
    case (level)
      CHG_PLENTY: if (v < thr) level = CHG_MID;
      CHG_MID: begin
        if (v > thr + PLENTY_HYST_MV) level = CHG_PLENTY;
        if (v < MID_LOW_MV) level = CHG_LOW;
      end
      CHG_LOW: begin
        if (v > LOW_MID_MV) level = CHG_MID;
        if (v < LOW_VLOW_MV) level = CHG_VLOW;
      end
      default: if (v > VLOW_LOW_MV) level = CHG_LOW;
    endcase
  endfunction

  // Advances the predictor by one command and returns the reading it yields.
  function automatic reading_t monitor_step(cmd_t c);
    reading_t    r;
    int unsigned trim;
    int unsigned span;
    int unsigned div;
    int unsigned avg;
    r.upd = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        if (acc_count < AVG_SAMPLES) begin
          acc_sum   = acc_sum + c.sample;
          acc_count = acc_count + 7'd1;
          if (acc_min > c.sample) acc_min = c.sample;
          if (acc_max < c.sample) acc_max = c.sample;
        end else begin
          trim    = acc_min + acc_max;
          span    = (acc_sum > trim) ? acc_sum - trim : 0;
          div     = (acc_count > 2) ? acc_count - 2 : 1;
          avg     = span / div;
          held_mv = (avg > MV_MAX) ? MV_MAX : avg[MV_W-1:0];
          acc_sum   = '0;
          acc_count = '0;
          acc_min   = MV_MAX;
          acc_max   = '0;
          r.upd     = 1'b1;
        end
      end
      MODE_EVAL: begin
        if (held_mv > FAULT_MV) begin
          alert_st = (held_mv <= c.athr);
          fault_st = 1'b0;
        end else begin
          alert_st = 1'b0;
          fault_st = 1'b1;
        end
        step_level(c.turbo);
      end
      MODE_PRESET: begin
        held_mv = c.sample;
        step_level(c.turbo);
      end
      default: ;
    endcase
    r.level = level;
    r.held  = held_mv;
    r.alert = alert_st;
    r.fault = fault_st;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ------------------------------------------------------------------
  // Clock and the run limit.
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("battery_level_hysteresis_monitor_test failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Item sender. Fields change on the falling edge; a transfer happens
  // on the rising edge with valid and ready both high. The reading owed
  // is queued at the transfer edge, before the block can deliver it.
  // valid stays high across back-to-back transfers.
  // ------------------------------------------------------------------
  task automatic offer(input cmd_t c, input bit pinned, input reading_t want);
    reading_t got;
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item_ch.mode               = c.mode;
    item_ch.sample_mv          = c.sample;
    item_ch.turbo_active       = c.turbo;
    item_ch.alert_threshold_mv = c.athr;
    item_ch.valid              = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    got = monitor_step(c);
    pending_readings.push_back(pinned ? want : got);
    accepted++;
    @(negedge clk);
  endtask

  // Voltage mostly near the level thresholds, sometimes anywhere in range.
  function automatic logic [MV_W-1:0] pick_mv();
    if ($urandom_range(0, 3) == 0) return MV_W'($urandom_range(0, MV_MAX));
    return MV_W'($urandom_range(2500, 4300));
  endfunction

  initial begin
    cmd_t        c;
    reading_t    want;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned tick_center;

    item_ch.valid              = 1'b0;
    item_ch.mode               = MODE_NONE;
    item_ch.sample_mv          = '0;
    item_ch.turbo_active       = 1'b0;
    item_ch.alert_threshold_mv = '0;
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      c.mode     = dir_rows[i].mode;
      c.sample   = dir_rows[i].sample;
      c.turbo    = dir_rows[i].turbo;
      c.athr     = dir_rows[i].athr;
      want.level = dir_rows[i].level;
      want.held  = dir_rows[i].held;
      want.alert = dir_rows[i].alert;
      want.fault = dir_rows[i].fault;
      want.upd   = dir_rows[i].upd;
      offer(c, dir_rows[i].pinned, want);
    end

    // Random part: mostly sample ticks so averages close regularly; each
    // window clusters around its own center so the averaged voltage
    // wanders across the level thresholds.
    tick_center = pick_mv();
    for (int n = 0; n < ITEM_COUNT; n++) begin
      calm    = (n >= ITEM_COUNT - CALM_TAIL);
      pick    = $urandom_range(0, 99);
      c.turbo = 1'($urandom_range(0, 1));
      c.athr  = MV_W'($urandom_range(0, MV_MAX));
      if (pick < 55) begin
        c.mode = MODE_TICK;
        if (acc_count == 0) tick_center = pick_mv();
        if ($urandom_range(0, 7) == 0) begin
          c.sample = MV_W'($urandom_range(0, MV_MAX));
        end else begin
          lo = (tick_center > 300) ? tick_center - 300 : 0;
          hi = (tick_center + 300 > MV_MAX) ? MV_MAX : tick_center + 300;
          c.sample = MV_W'($urandom_range(lo, hi));
        end
      end else if (pick < 80) begin
        c.mode   = MODE_EVAL;
        c.sample = MV_W'($urandom_range(0, MV_MAX));
        // threshold often just around the held voltage to hit the edge
        if ($urandom_range(0, 1) == 0) begin
          lo = (held_mv > 40) ? held_mv - 40 : 0;
          hi = (held_mv + 40 > MV_MAX) ? MV_MAX : held_mv + 40;
          c.athr = MV_W'($urandom_range(lo, hi));
        end
      end else if (pick < 95) begin
        c.mode   = MODE_PRESET;
        c.sample = pick_mv();
      end else begin
        c.mode   = MODE_NONE;
        c.sample = MV_W'($urandom_range(0, MV_MAX));
      end
      offer(c, 1'b0, want);
    end
    item_ch.valid = 1'b0;

    // Drain, then a short quiet window to catch stray transfers.
    wait (pending_readings.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("battery_level_hysteresis_monitor_test passed");
    end else begin
      $display("battery_level_hysteresis_monitor_test failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Result receiver. ready toggles in random bursts; once, after
  // HOLD_AFTER transfers, it stays low for HOLD_CYCLES so both block
  // registers fill and item.ready drops while the sender keeps offering.
  // ------------------------------------------------------------------
  initial begin
    bit held_off;
    held_off = 1'b0;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_off && accepted >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checker: every transfer is matched against the oldest owed
  // reading, field by field.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        note_mismatch("unexpected result transfer, held_voltage_mv",
                      result_ch.held_voltage_mv, 0);
      end else begin
        want = pending_readings.pop_front();
        if (result_ch.charge_level !== want.level)
          note_mismatch("charge_level", result_ch.charge_level, want.level);
        if (result_ch.held_voltage_mv !== want.held)
          note_mismatch("held_voltage_mv", result_ch.held_voltage_mv, want.held);
        if (result_ch.alert_flag !== want.alert)
          note_mismatch("alert_flag", result_ch.alert_flag, want.alert);
        if (result_ch.fault_flag !== want.fault)
          note_mismatch("fault_flag", result_ch.fault_flag, want.fault);
        if (result_ch.average_updated !== want.upd)
          note_mismatch("average_updated", result_ch.average_updated, want.upd);
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/blhm_pkg.sv
rtl/core/blhm_if.sv
rtl/core/blhm_avg.sv
rtl/core/blhm_level.sv
rtl/core/battery_level_hysteresis_monitor.sv
test/battery_level_hysteresis_monitor_test.sv
